// ===== sv/dq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the double-ended queue: sizes, opcode and status codes,
// and the control bundle that drives the row of storage cells. No dependencies.
package dq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned CNT_BITS    = $clog2(DEPTH + 1);
  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_PEEK      = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY_ERROR = 2'd1,
    ST_FULL_ERROR  = 2'd2
  } status_e;

  typedef struct packed {
    logic                 ins_front;
    logic                 ins_back;
    logic                 rem_front;
    logic                 rem_back;
    logic [WORD_BITS-1:0] value;
  } cell_ctl_t;

endpackage

// ===== sv/dq_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces for the request and response channels of the queue.
// Depends on dq_pkg.
interface dq_req_if;
  import dq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [OP_BITS-1:0]          opcode;
  logic signed [WORD_BITS-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface dq_rsp_if;
  import dq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] front_value;
  logic signed [WORD_BITS-1:0] back_value;
  logic [CNT_BITS-1:0]         count;
  logic                        is_empty;
  logic [STATUS_BITS-1:0]      status;

  modport source (output valid, output front_value, output back_value, output count,
                  output is_empty, output status, input ready);
  modport sink (input valid, input front_value, input back_value, input count,
                input is_empty, input status, output ready);
endinterface

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue: a row of storage cells, the
// element counter and the response register. Depends on dq_pkg, dq_if, dq_cell.
//
//  channel | direction | beat contents
//  req_i   | in        | opcode, value
//  rsp_o   | out       | front_value, back_value, count, is_empty, status
//
// Every request beat yields one response beat in the cycle after acceptance.
// A request is taken every cycle while the response register is empty or drained.
// All cells shift in the same cycle; the response register captures their next state.
// Reset empties the queue at once; stored words keep no reset value.
// A stalled response holds req_i.ready low until it is taken.
module double_ended_queue (
  input logic    clk_i,
  input logic    rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);
  import dq_pkg::*;

  logic                 accept;
  logic                 full, empty;
  cell_ctl_t            ctl;
  status_e              status_d;
  logic [CNT_BITS-1:0]  count_q, count_d;

  logic [DEPTH:0]       vld_q, vld_d;
  logic [WORD_BITS-1:0] dat_q [DEPTH+1];
  logic [WORD_BITS-1:0] dat_d [DEPTH];
  logic [WORD_BITS-1:0] front_d, back_d;

  logic                 rsp_valid_q;
  logic [WORD_BITS-1:0] front_q, back_q;
  logic [CNT_BITS-1:0]  rsp_count_q;
  logic                 empty_q;
  status_e              status_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q == CNT_BITS'(DEPTH));
  assign empty       = (count_q == '0);

  always_comb begin
    ctl       = '0;
    ctl.value = req_i.value;
    count_d   = count_q;
    status_d  = ST_OK;
    if (accept) begin
      unique case (opcode_e'(req_i.opcode))
        OP_INS_FRONT, OP_INS_BACK: begin
          if (full) begin
            status_d = ST_FULL_ERROR;
          end else begin
            ctl.ins_front = (opcode_e'(req_i.opcode) == OP_INS_FRONT);
            ctl.ins_back  = (opcode_e'(req_i.opcode) == OP_INS_BACK);
            count_d       = count_q + CNT_BITS'(1);
          end
        end
        OP_REM_FRONT, OP_REM_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY_ERROR;
          end else begin
            ctl.rem_front = (opcode_e'(req_i.opcode) == OP_REM_FRONT);
            ctl.rem_back  = (opcode_e'(req_i.opcode) == OP_REM_BACK);
            count_d       = count_q - CNT_BITS'(1);
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  assign vld_q[DEPTH] = 1'b0;
  assign vld_d[DEPTH] = 1'b0;
  assign dat_q[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 prev_valid;
    logic [WORD_BITS-1:0] prev_data;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_data  = req_i.value;
    end else begin : g_body
      assign prev_valid = vld_q[i-1];
      assign prev_data  = dat_q[i-1];
    end

    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_valid_i (prev_valid),
      .prev_data_i  (prev_data),
      .next_valid_i (vld_q[i+1]),
      .next_data_i  (dat_q[i+1]),
      .valid_o      (vld_q[i]),
      .data_o       (dat_q[i]),
      .valid_d_o    (vld_d[i]),
      .data_d_o     (dat_d[i])
    );
  end

  // The back word sits in the one valid cell whose successor is empty.
  always_comb begin
    front_d = vld_d[0] ? dat_d[0] : '0;
    back_d  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (vld_d[i] && !vld_d[i+1]) begin
        back_d = back_d | dat_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_q     <= front_d;
      back_q      <= back_d;
      rsp_count_q <= count_d;
      empty_q     <= (count_d == '0);
      status_q    <= status_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.front_value = front_q;
  assign rsp_o.back_value  = back_q;
  assign rsp_o.count       = rsp_count_q;
  assign rsp_o.is_empty    = empty_q;
  assign rsp_o.status      = status_q;

endmodule

// ===== sv/dq_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the queue: a word and a valid bit that move to or
// from the neighboring cells on front operations. Depends on dq_pkg.
module dq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dq_pkg::cell_ctl_t            ctl_i,
  input  logic                         prev_valid_i,
  input  logic [dq_pkg::WORD_BITS-1:0] prev_data_i,
  input  logic                         next_valid_i,
  input  logic [dq_pkg::WORD_BITS-1:0] next_data_i,
  output logic                         valid_o,
  output logic [dq_pkg::WORD_BITS-1:0] data_o,
  output logic                         valid_d_o,
  output logic [dq_pkg::WORD_BITS-1:0] data_d_o
);
  import dq_pkg::*;

  logic                 valid_q, valid_d;
  logic [WORD_BITS-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctl_i.ins_front) begin
      valid_d = prev_valid_i;
      data_d  = prev_data_i;
    end else if (ctl_i.ins_back) begin
      if (!valid_q && prev_valid_i) begin
        valid_d = 1'b1;
        data_d  = ctl_i.value;
      end
    end else if (ctl_i.rem_front) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (ctl_i.rem_back) begin
      valid_d = valid_q && next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o   = valid_q;
  assign data_o    = data_q;
  assign valid_d_o = valid_d;
  assign data_d_o  = data_d;

endmodule

// ===== sv/dq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the double-ended queue response channel, attached to
// the top level by the bind below. Depends on dq_pkg and double_ended_queue.
module dq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [dq_pkg::WORD_BITS-1:0] front_i,
  input logic [dq_pkg::WORD_BITS-1:0] back_i,
  input logic [dq_pkg::CNT_BITS-1:0]  count_i,
  input logic                         empty_i,
  input logic [dq_pkg::STATUS_BITS-1:0] status_i
);
  import dq_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("Response beat dropped while stalled.");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (empty_i == (count_i == '0)))
    else $error("Empty flag disagrees with count.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && empty_i |-> (front_i == '0) && (back_i == '0))
    else $error("Empty queue shows nonzero words.");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (count_i <= CNT_BITS'(DEPTH)))
    else $error("Count exceeds capacity.");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |->
      ((status_i != STATUS_BITS'(ST_FULL_ERROR)) || (count_i == CNT_BITS'(DEPTH))) &&
      ((status_i != STATUS_BITS'(ST_EMPTY_ERROR)) || (count_i == '0)))
    else $error("Error status inconsistent with count.");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .front_i     (rsp_o.front_value),
  .back_i      (rsp_o.back_value),
  .count_i     (rsp_o.count),
  .empty_i     (rsp_o.is_empty),
  .status_i    (rsp_o.status)
);
